@@ rtl/core/slkc_pkg.sv @@
// ----------------------------------------------------------------------------
// slkc_pkg
// Shared constants and codes for the sharded LRU key cache.
// ----------------------------------------------------------------------------
package slkc_pkg;

  localparam int SHARDS   = 20;
  localparam int WAYS     = 500;
  localparam int ENTRIES  = SHARDS * WAYS;
  localparam int KEY_DIV  = 100;

  localparam int SLOT_W   = $clog2(WAYS);
  localparam int CNT_W    = $clog2(WAYS + 1);
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int SHARD_IW = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int SHARD_W  = 5;
  localparam int KEY_W    = 32;
  localparam int LINK_W   = 2 * SLOT_W;

  // reciprocal constants for the two divisions by constants
  localparam logic [63:0] RECIP_DIV   = ((64'd1 << 38) + 64'(KEY_DIV) - 64'd1) / 64'(KEY_DIV);
  localparam logic [63:0] RECIP_SHARD = ((64'd1 << 30) + 64'(SHARDS) - 64'd1) / 64'(SHARDS);

  // commands
  localparam logic [1:0] CMD_FIND_MRU  = 2'd0;
  localparam logic [1:0] CMD_FIND_KEEP = 2'd1;
  localparam logic [1:0] CMD_ERASE     = 2'd2;

  // result status codes
  localparam logic [1:0] ST_HIT       = 2'd0;
  localparam logic [1:0] ST_INSERTED  = 2'd1;
  localparam logic [1:0] ST_ERASED    = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

@@ rtl/core/sharded_lru_key_cache.sv @@
// ----------------------------------------------------------------------------
// sharded_lru_key_cache
// Keys spread over independent LRU sets kept as linked lists in block memory.
// ----------------------------------------------------------------------------
// One word in, one word out. The key's shard is worked out by two reciprocal
// multiplies. Then every slot of the shard is read from the single-ported key
// memory, one a cycle, to find the key and the lowest free slot. After that, at
// most eight link-memory accesses update the recency list. One command is in
// flight at a time; the next word is taken while a result waits on the output.
// After reset the block clears the valid bits of all ENTRIES words of the key
// memory and accepts no word during that pass.
module sharded_lru_key_cache
  import slkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] user_key
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [4:0] shard_index, [5] evicted, [37:6] evicted_key, pad
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DIV1   = 5'd2;
  localparam logic [4:0] S_DIV2   = 5'd3;
  localparam logic [4:0] S_DIV3   = 5'd4;
  localparam logic [4:0] S_DIV4   = 5'd5;
  localparam logic [4:0] S_BASE   = 5'd6;
  localparam logic [4:0] S_SCAN   = 5'd7;
  localparam logic [4:0] S_DECIDE = 5'd8;
  localparam logic [4:0] S_U_RD   = 5'd9;
  localparam logic [4:0] S_U_GET  = 5'd10;
  localparam logic [4:0] S_A_RD   = 5'd11;
  localparam logic [4:0] S_A_WR   = 5'd12;
  localparam logic [4:0] S_B_RD   = 5'd13;
  localparam logic [4:0] S_B_WR   = 5'd14;
  localparam logic [4:0] S_P_WR0  = 5'd15;
  localparam logic [4:0] S_P_RD   = 5'd16;
  localparam logic [4:0] S_P_WR   = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;

  logic [4:0] state;

  // memories
  logic [KEY_W:0]      key_mem  [ENTRIES];
  logic [LINK_W-1:0]   link_mem [ENTRIES];
  logic [KEY_W:0]      key_rdata;
  logic [LINK_W-1:0]   link_rdata;
  logic                key_we, key_re, link_we, link_re;
  logic [ADDR_W-1:0]   key_addr, link_addr;
  logic [KEY_W:0]      key_wdata;
  logic [LINK_W-1:0]   link_wdata;

  // per-shard list registers
  logic [SLOT_W-1:0]   head_arr [SHARDS];
  logic [SLOT_W-1:0]   tail_arr [SHARDS];
  logic [CNT_W-1:0]    cnt_arr  [SHARDS];

  // command context
  logic [1:0]          cmd;
  logic [KEY_W-1:0]    ukey;
  logic [31:0]         mag;
  logic [63:0]         p1;
  logic [25:0]         q;
  logic [51:0]         p2;
  logic [SHARD_IW-1:0] shard;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   clr_addr;

  // scan
  logic [CNT_W-1:0]    rw;
  logic                rv;
  logic [SLOT_W-1:0]   cw;
  logic                found, have_free;
  logic [SLOT_W-1:0]   hit_slot, free_slot;
  logic [KEY_W-1:0]    tail_key;

  // working copy of the shard list
  logic [SLOT_W-1:0]   hd, tl;
  logic [CNT_W-1:0]    cnt;

  // update plan
  logic [SLOT_W-1:0]   xs, ps, ln, lo;
  logic                do_push, need_b;
  logic [1:0]          res_status;
  logic                res_evicted;
  logic [KEY_W-1:0]    res_key;

  logic [25:0]         qd;
  logic [25:0]         rem;
  logic                full;
  logic [SLOT_W-1:0]   ins_slot;

  assign qd       = p2[51:30] <= 22'h3fffff ? {4'd0, p2[51:30]} : 26'd0;
  assign rem      = q - 26'(qd * 26'(SHARDS));
  assign full     = (cnt >= CNT_W'(WAYS));
  assign ins_slot = full ? tl : free_slot;
  assign s_tready = (state == S_IDLE);

  // memory port control
  always_comb begin
    key_we     = 1'b0;
    key_re     = 1'b0;
    key_addr   = clr_addr;
    key_wdata  = '0;
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_addr  = base;
    link_wdata = '0;
    case (state)
      S_CLEAR: begin
        key_we = 1'b1;
      end
      S_SCAN: begin
        key_re   = (rw < CNT_W'(WAYS));
        key_addr = base + ADDR_W'(rw[SLOT_W-1:0]);
      end
      S_DECIDE: begin
        if (cmd == CMD_ERASE) begin
          key_we   = found;
          key_addr = base + ADDR_W'(hit_slot);
        end else if (!found) begin
          key_we    = 1'b1;
          key_addr  = base + ADDR_W'(ins_slot);
          key_wdata = {1'b1, ukey};
        end
      end
      S_U_RD: begin
        link_re   = 1'b1;
        link_addr = base + ADDR_W'(xs);
      end
      S_A_RD: begin
        link_re   = 1'b1;
        link_addr = base + ADDR_W'(ln);
      end
      S_A_WR: begin
        link_we    = 1'b1;
        link_addr  = base + ADDR_W'(ln);
        link_wdata = {link_rdata[LINK_W-1:SLOT_W], lo};
      end
      S_B_RD: begin
        link_re   = 1'b1;
        link_addr = base + ADDR_W'(lo);
      end
      S_B_WR: begin
        link_we    = 1'b1;
        link_addr  = base + ADDR_W'(lo);
        link_wdata = {ln, link_rdata[SLOT_W-1:0]};
      end
      S_P_WR0: begin
        link_we    = 1'b1;
        link_addr  = base + ADDR_W'(ps);
        link_wdata = {ps, (cnt == '0) ? ps : hd};
      end
      S_P_RD: begin
        link_re   = 1'b1;
        link_addr = base + ADDR_W'(hd);
      end
      S_P_WR: begin
        link_we    = 1'b1;
        link_addr  = base + ADDR_W'(hd);
        link_wdata = {ps, link_rdata[SLOT_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  // key memory
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_addr] <= key_wdata;
    if (key_re) key_rdata <= key_mem[key_addr];
  end

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_addr] <= link_wdata;
    if (link_re) link_rdata <= link_mem[link_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd  <= s_tuser;
        ukey <= s_tdata;
        mag  <= s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
      end
      S_DIV1: p1 <= 64'(mag) * RECIP_DIV;
      S_DIV2: q  <= p1[63:38];
      S_DIV3: p2 <= 52'(52'(q) * 52'(RECIP_SHARD));
      S_DIV4: shard <= rem[SHARD_IW-1:0];
      S_BASE: begin
        base      <= ADDR_W'(32'(shard) * 32'(WAYS));
        hd        <= head_arr[shard];
        tl        <= tail_arr[shard];
        cnt       <= cnt_arr[shard];
        rw        <= '0;
        rv        <= 1'b0;
        found     <= 1'b0;
        have_free <= 1'b0;
        hit_slot  <= '0;
        free_slot <= '0;
        tail_key  <= '0;
      end
      S_SCAN: begin
        // one slot issued and one slot checked each cycle
        if (rw < CNT_W'(WAYS)) rw <= rw + CNT_W'(1);
        rv <= (rw < CNT_W'(WAYS));
        cw <= rw[SLOT_W-1:0];
        if (rv) begin
          if (key_rdata[KEY_W] && key_rdata[KEY_W-1:0] == ukey && !found) begin
            found    <= 1'b1;
            hit_slot <= cw;
          end
          if (!key_rdata[KEY_W] && !have_free) begin
            have_free <= 1'b1;
            free_slot <= cw;
          end
          if (cw == tl) tail_key <= key_rdata[KEY_W-1:0];
        end
      end
      S_DECIDE: begin
        if (cmd == CMD_ERASE) begin
          res_status  <= found ? ST_ERASED : ST_NOT_FOUND;
          res_evicted <= 1'b0;
          res_key     <= '0;
          xs          <= hit_slot;
          ps          <= hit_slot;
          do_push     <= 1'b0;
        end else if (found) begin
          res_status  <= ST_HIT;
          res_evicted <= 1'b0;
          res_key     <= '0;
          xs          <= hit_slot;
          ps          <= hit_slot;
          do_push     <= 1'b1;
        end else begin
          res_status  <= ST_INSERTED;
          res_evicted <= full;
          res_key     <= full ? tail_key : '0;
          xs          <= tl;
          ps          <= ins_slot;
          do_push     <= 1'b1;
        end
      end
      S_U_GET: begin
        // detach the slot from its neighbors
        ln     <= link_rdata[LINK_W-1:SLOT_W];
        lo     <= link_rdata[SLOT_W-1:0];
        need_b <= (cnt > CNT_W'(1)) && (xs != tl);
        if (cnt <= CNT_W'(1)) begin
          hd <= '0;
          tl <= '0;
        end else begin
          if (xs == hd) hd <= link_rdata[SLOT_W-1:0];
          if (xs == tl) tl <= link_rdata[LINK_W-1:SLOT_W];
        end
        if (cnt != '0) cnt <= cnt - CNT_W'(1);
      end
      S_P_WR0: begin
        if (cnt == '0) begin
          hd  <= ps;
          tl  <= ps;
          cnt <= cnt + CNT_W'(1);
        end
      end
      S_P_WR: begin
        hd  <= ps;
        cnt <= cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // sequencer, shard list write-back and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < SHARDS; i++) begin
        head_arr[i] <= '0;
        tail_arr[i] <= '0;
        cnt_arr[i]  <= '0;
      end
    end else begin
      if (state == S_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE:  if (s_tvalid) state <= S_DIV1;
        S_DIV1:  state <= S_DIV2;
        S_DIV2:  state <= S_DIV3;
        S_DIV3:  state <= S_DIV4;
        S_DIV4:  state <= S_BASE;
        S_BASE:  state <= S_SCAN;
        S_SCAN:  if (rw == CNT_W'(WAYS) && !rv) state <= S_DECIDE;
        S_DECIDE: begin
          if (cmd == CMD_ERASE) begin
            state <= found ? S_U_RD : S_FIN;
          end else if (found) begin
            state <= (cmd == CMD_FIND_MRU && hit_slot != hd) ? S_U_RD : S_FIN;
          end else begin
            state <= full ? S_U_RD : S_P_WR0;
          end
        end
        S_U_RD:  state <= S_U_GET;
        S_U_GET: begin
          if (cnt > CNT_W'(1) && xs != hd) state <= S_A_RD;
          else if (cnt > CNT_W'(1) && xs != tl) state <= S_B_RD;
          else state <= do_push ? S_P_WR0 : S_FIN;
        end
        S_A_RD:  state <= S_A_WR;
        S_A_WR:  state <= need_b ? S_B_RD : (do_push ? S_P_WR0 : S_FIN);
        S_B_RD:  state <= S_B_WR;
        S_B_WR:  state <= do_push ? S_P_WR0 : S_FIN;
        S_P_WR0: state <= (cnt == '0) ? S_FIN : S_P_RD;
        S_P_RD:  state <= S_P_WR;
        S_P_WR:  state <= S_FIN;
        S_FIN: begin
          head_arr[shard] <= hd;
          tail_arr[shard] <= tl;
          cnt_arr[shard]  <= cnt;
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tuser <= res_status;
      m_tdata <= {2'b00, res_key, res_evicted, SHARD_W'(shard)};
    end
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives find and erase words into the sharded LRU key cache and checks every
// result word against a recency-list predictor kept per shard.
// ----------------------------------------------------------------------------
module tb_top;
  import slkc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 40000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] user_key
  logic [1:0]  s_tuser;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [4:0] shard_index, [5] evicted, [37:6] evicted_key, pad
  logic [1:0]  m_tuser;   // [1:0] status

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  shard;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic        known;
    logic [1:0]  status;
    logic        evicted;
  } stim_row_t;

  sharded_lru_key_cache dut (.*);

  // predictor state: each shard is a queue of keys, most recent first
  logic [31:0]   recency_list[SHARDS][$];
  cache_result_t pending_results[$];
  logic          pending_known[$];
  cache_result_t typed_results[$];
  int            error_count;
  int            idle_cycles;
  bit            tail_phase;
  bit            hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [4:0] shard_for(logic [31:0] key);
    logic [31:0] mag;
    mag = key[31] ? (32'd0 - key) : key;
    return 5'((mag / KEY_DIV) % SHARDS);
  endfunction

  function automatic cache_result_t cache_lookup(logic [1:0] cmd, logic [31:0] key);
    cache_result_t r;
    int s;
    int pos;
    s = shard_for(key);
    r = '0;
    r.shard = 5'(s);
    pos = -1;
    for (int i = 0; i < recency_list[s].size(); i++) begin
      if (pos < 0 && recency_list[s][i] == key) pos = i;
    end
    if (cmd == CMD_ERASE) begin
      if (pos >= 0) begin
        recency_list[s].delete(pos);
        r.status = ST_ERASED;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (pos >= 0) begin
      r.status = ST_HIT;
      if (cmd == CMD_FIND_MRU) begin
        recency_list[s].delete(pos);
        recency_list[s].insert(0, key);
      end
    end else begin
      r.status = ST_INSERTED;
      if (recency_list[s].size() >= WAYS) begin
        r.evicted = 1'b1;
        r.evicted_key = recency_list[s][recency_list[s].size() - 1];
        recency_list[s].delete(recency_list[s].size() - 1);
      end
      recency_list[s].insert(0, key);
    end
    return r;
  endfunction

  // picks a key of a chosen shard with small offsets so keys repeat
  function automatic logic [31:0] key_in_shard(int s, int spread);
    int v;
    v = (s + SHARDS * $urandom_range(0, spread)) * KEY_DIV + $urandom_range(0, 3);
    return $urandom_range(0, 1) ? 32'(v) : 32'(-v);
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [31:0] key, logic known,
                           logic [1:0] st, logic ev);
    cache_result_t r;
    if (!tail_phase && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = cache_lookup(cmd, key);
    pending_results.insert(pending_results.size(), r);
    pending_known.insert(pending_known.size(), known);
    typed_results.insert(typed_results.size(),
                         cache_result_t'{status: st, shard: r.shard, evicted: ev,
                                         evicted_key: 32'd0});
    @(negedge clk);
  endtask

  // receiver side with random stall bursts and one long hold-off
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    cache_result_t got, want, typed;
    logic known;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = '{status: m_tuser, shard: m_tdata[4:0], evicted: m_tdata[5],
                evicted_key: m_tdata[37:6]};
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          error_count++;
        end else begin
          want  = pending_results.pop_front();
          known = pending_known.pop_front();
          typed = typed_results.pop_front();
          // directed rows with a typed-in expectation
          if (known && got.status != typed.status) begin
            $error("status expected %0d actual %0d", typed.status, got.status);
            error_count++;
          end
          if (known && got.evicted != typed.evicted) begin
            $error("evicted expected %0d actual %0d", typed.evicted, got.evicted);
            error_count++;
          end
          if (got.status != want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            error_count++;
          end
          if (got.shard != want.shard) begin
            $error("shard_index expected %0d actual %0d", want.shard, got.shard);
            error_count++;
          end
          if (got.evicted != want.evicted) begin
            $error("evicted expected %0d actual %0d", want.evicted, got.evicted);
            error_count++;
          end
          if (got.evicted_key != want.evicted_key) begin
            $error("evicted_key expected %0h actual %0h", want.evicted_key,
                   got.evicted_key);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int n;
    int s;
    logic [1:0] cmd;
    logic [31:0] key;
    logic [31:0] seen[$];
    error_count = 0;
    tail_phase = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_FIND_MRU;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows: extremes, every command, hits, erases, the unused code
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_MRU,  32'h8000_0000, 1, ST_INSERTED,  0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_MRU,  32'h7FFF_FFFF, 1, ST_INSERTED,  0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_KEEP, 32'h0000_0000, 1, ST_INSERTED,  0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_MRU,  32'h8000_0000, 1, ST_HIT,       0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_KEEP, 32'h7FFF_FFFF, 1, ST_HIT,       0});
    rows.insert(rows.size(), stim_row_t'{2'd3,          32'h0000_0000, 1, ST_HIT,       0});
    rows.insert(rows.size(), stim_row_t'{2'd3,          32'hFFFF_FFFF, 1, ST_INSERTED,  0});
    rows.insert(rows.size(), stim_row_t'{CMD_ERASE,     32'h0000_0063, 1, ST_NOT_FOUND, 0});
    rows.insert(rows.size(), stim_row_t'{CMD_ERASE,     32'hFFFF_FFFF, 1, ST_ERASED,    0});
    rows.insert(rows.size(), stim_row_t'{CMD_ERASE,     32'hFFFF_FFFF, 1, ST_NOT_FOUND, 0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_MRU,  32'h0000_0064, 0, ST_HIT,       0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_MRU,  32'hFFFF_FF9C, 0, ST_HIT,       0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_KEEP, 32'h0000_07CF, 0, ST_HIT,       0});
    rows.insert(rows.size(), stim_row_t'{CMD_ERASE,     32'h8000_0000, 1, ST_ERASED,    0});
    rows.insert(rows.size(), stim_row_t'{CMD_ERASE,     32'h0000_0000, 1, ST_ERASED,    0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_MRU,  32'h5555_5555, 0, ST_HIT,       0});
    rows.insert(rows.size(), stim_row_t'{CMD_FIND_MRU,  32'hAAAA_AAAA, 0, ST_HIT,       0});
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].key, rows[i].known,
                                rows[i].status, rows[i].evicted);

    // fill shard 7 past capacity so the tail is evicted, under a long stall
    hold_off = 1'b1;
    for (int i = 0; i < WAYS + 40; i++) begin
      key = 32'((7 + SHARDS * i) * KEY_DIV + 1);
      cmd = (i % 3 == 0) ? CMD_FIND_KEEP : CMD_FIND_MRU;
      send_word(cmd, key, 0, ST_HIT, 0);
      if (i % 37 == 5) send_word(CMD_FIND_MRU, 32'((7 + SHARDS * (i / 2)) * KEY_DIV + 1),
                                 0, ST_HIT, 0);
    end

    // random words, mostly keys that repeat within few shards
    n = 0;
    while (n < 150) begin
      if (n > 120) tail_phase = 1'b1;
      cmd = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        key = $urandom();
      end else if (seen.size() > 0 && $urandom_range(0, 1)) begin
        key = seen[$urandom_range(0, seen.size() - 1)];
      end else begin
        s = $urandom_range(0, 3);
        key = key_in_shard(s, 30);
      end
      if (cmd != CMD_ERASE) seen.insert(seen.size(), key);
      send_word(cmd, key, 0, ST_HIT, 0);
      n++;
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/slkc_pkg.sv
rtl/core/sharded_lru_key_cache.sv
verif/tb_top.sv
